FILE: src/jhds_pkg.sv
// ----------------------------------------------------------------------------
// jhds_pkg: shared types and codes for the JPEG header dimension scanner
// Request, status and marker codes, the minimum frame content size and the result beat type.
// ----------------------------------------------------------------------------
package jhds_pkg;

  // request codes on the input channel
  localparam logic [1:0] REQ_DATA  = 2'd0;
  localparam logic [1:0] REQ_EOS   = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_IO  = 2'd1;
  localparam logic [1:0] ST_FMT = 2'd2;
  localparam logic [1:0] ST_MEM = 2'd3;

  // marker bytes
  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] MARKER_SOI    = 8'hD8;
  localparam logic [7:0] MARKER_SOF0   = 8'hC0;

  // smallest frame content that holds both dimensions
  localparam logic [15:0] FRAME_MIN_BYTES = 16'd5;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } jhds_result_t;

endpackage

FILE: src/jhds_in_if.sv
// ----------------------------------------------------------------------------
// jhds_in_if: input byte channel
// Valid/ready channel carrying one request and one file byte per beat.
// ----------------------------------------------------------------------------
interface jhds_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

FILE: src/jhds_out_if.sv
// ----------------------------------------------------------------------------
// jhds_out_if: result channel
// Valid/ready channel carrying one status with frame dimensions per beat.
// ----------------------------------------------------------------------------
interface jhds_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] image_width;
  logic [15:0] image_height;

  modport source (output valid, output status, output image_width, output image_height,
                  input ready);
  modport sink   (input valid, input status, input image_width, input image_height,
                  output ready);
endinterface

FILE: src/jhds_core.sv
// ----------------------------------------------------------------------------
// jhds_core: marker segment parser
// Per-byte state update; flags a result on the byte that decides the scan.
// ----------------------------------------------------------------------------
module jhds_core #(
  parameter int FRAME_BUFFER_BYTES = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  beat,
  input  logic [1:0]            req_type,
  input  logic [7:0]            data_byte,
  output logic                  res_valid,
  output jhds_pkg::jhds_result_t res
);
  import jhds_pkg::*;

  localparam logic [15:0] FRAME_LIMIT = 16'(FRAME_BUFFER_BYTES);

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_FRAME  = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // content position saturates once both dimensions are in
  localparam logic [2:0] CIDX_SAT = 3'd5;

  logic [2:0]  phase_r,     phase_nxt;
  logic [7:0]  prev_byte_r, prev_byte_nxt;
  logic [1:0]  hidx_r,      hidx_nxt;
  logic [15:0] seg_mark_r,  seg_mark_nxt;
  logic [15:0] remain_r,    remain_nxt;
  logic [2:0]  cidx_r,      cidx_nxt;
  logic [15:0] height_r,    height_nxt;
  logic [15:0] width_r,     width_nxt;

  logic [15:0] seg_len;
  logic [15:0] content_len;
  logic [15:0] remain_dec;

  assign seg_len     = {remain_r[15:8], data_byte};
  assign content_len = seg_len - 16'd2;
  assign remain_dec  = remain_r - 16'd1;

  always_comb begin
    phase_nxt     = phase_r;
    prev_byte_nxt = prev_byte_r;
    hidx_nxt      = hidx_r;
    seg_mark_nxt  = seg_mark_r;
    remain_nxt    = remain_r;
    cidx_nxt      = cidx_r;
    height_nxt    = height_r;
    width_nxt     = width_r;
    res_valid     = 1'b0;
    res           = '{status: ST_OK, image_width: '0, image_height: '0};

    if (beat) begin
      case (req_type)
        REQ_START: begin
          phase_nxt     = PH_SEARCH;
          prev_byte_nxt = '0;
          hidx_nxt      = '0;
          seg_mark_nxt  = '0;
          remain_nxt    = '0;
          cidx_nxt      = '0;
          height_nxt    = '0;
          width_nxt     = '0;
        end
        REQ_EOS: begin
          case (phase_r)
            PH_SEARCH, PH_HEADER, PH_FRAME: begin
              res_valid  = 1'b1;
              res.status = ST_IO;
              phase_nxt  = PH_DONE;
            end
            PH_SKIP: begin
              res_valid  = 1'b1;
              res.status = ST_FMT;
              phase_nxt  = PH_DONE;
            end
            default: ;
          endcase
        end
        REQ_DATA: begin
          case (phase_r)
            PH_SEARCH: begin
              prev_byte_nxt = data_byte;
              if (prev_byte_r == MARKER_PREFIX && data_byte == MARKER_SOI) begin
                phase_nxt = PH_HEADER;
                hidx_nxt  = '0;
              end
            end
            PH_HEADER: begin
              hidx_nxt = hidx_r + 2'd1;
              case (hidx_r)
                2'd0: seg_mark_nxt = {data_byte, 8'h00};
                2'd1: seg_mark_nxt = {seg_mark_r[15:8], data_byte};
                2'd2: remain_nxt   = {data_byte, 8'h00};
                default: begin
                  remain_nxt = content_len;
                  cidx_nxt   = '0;
                  if (seg_len <= 16'd2 || seg_mark_r[15:8] != MARKER_PREFIX) begin
                    res_valid  = 1'b1;
                    res.status = ST_FMT;
                    phase_nxt  = PH_DONE;
                  end else if (seg_mark_r[7:0] == MARKER_SOF0) begin
                    if (content_len > FRAME_LIMIT) begin
                      res_valid  = 1'b1;
                      res.status = ST_MEM;
                      phase_nxt  = PH_DONE;
                    end else if (content_len < FRAME_MIN_BYTES) begin
                      res_valid  = 1'b1;
                      res.status = ST_FMT;
                      phase_nxt  = PH_DONE;
                    end else begin
                      phase_nxt = PH_FRAME;
                    end
                  end else begin
                    phase_nxt = PH_SKIP;
                  end
                end
              endcase
            end
            PH_SKIP: begin
              remain_nxt = remain_dec;
              if (remain_dec == 16'd0) begin
                phase_nxt = PH_HEADER;
                hidx_nxt  = '0;
              end
            end
            PH_FRAME: begin
              case (cidx_r)
                3'd1: height_nxt = {data_byte, 8'h00};
                3'd2: height_nxt = {height_r[15:8], data_byte};
                3'd3: width_nxt  = {data_byte, 8'h00};
                3'd4: width_nxt  = {width_r[15:8], data_byte};
                default: ;
              endcase
              if (cidx_r != CIDX_SAT) begin
                cidx_nxt = cidx_r + 3'd1;
              end
              remain_nxt = remain_dec;
              if (remain_dec == 16'd0) begin
                res_valid        = 1'b1;
                res.status       = ST_OK;
                res.image_width  = width_nxt;
                res.image_height = height_nxt;
                phase_nxt        = PH_DONE;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEARCH;
      prev_byte_r <= '0;
      hidx_r      <= '0;
      seg_mark_r  <= '0;
      remain_r    <= '0;
      cidx_r      <= '0;
      height_r    <= '0;
      width_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      prev_byte_r <= prev_byte_nxt;
      hidx_r      <= hidx_nxt;
      seg_mark_r  <= seg_mark_nxt;
      remain_r    <= remain_nxt;
      cidx_r      <= cidx_nxt;
      height_r    <= height_nxt;
      width_r     <= width_nxt;
    end
  end

endmodule

FILE: src/jpeg_header_dimension_scanner.sv
// ----------------------------------------------------------------------------
// jpeg_header_dimension_scanner: top level
// Finds SOI, walks marker segments and reports the baseline frame size.
// ----------------------------------------------------------------------------
// Feed the JPEG file one byte per beat on the input channel (req_type data),
// mark the end of the file with an end-of-stream beat, and send a start beat
// to begin a new file. The block takes one beat per cycle: each byte costs a
// single state update in the parser, and the result for the deciding byte is
// presented from the output register on the next cycle. At most one result
// beat comes out per scan: success with width and height once the whole SOF0
// content has arrived, or an error status (io, format, memory) with zero
// dimensions. After that, bytes and end-of-stream beats are absorbed silently
// until the next start beat. Input ready drops only while a result sits in
// the output register and the sink is not taking it. FRAME_BUFFER_BYTES is
// the largest SOF0 content length accepted before reporting out-of-memory.
module jpeg_header_dimension_scanner #(
  parameter int FRAME_BUFFER_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  jhds_in_if.sink    in_ch,
  jhds_out_if.source out_ch
);
  import jhds_pkg::*;

  logic         in_beat;
  logic         res_valid;
  jhds_result_t res;

  logic         out_valid_r, out_valid_nxt;
  jhds_result_t out_data_r;

  // Accept whenever the output register is free or is draining this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_beat     = in_ch.valid && in_ch.ready;

  jhds_core #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (in_beat),
    .req_type  (in_ch.req_type),
    .data_byte (in_ch.data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Load a new result, drop a taken one, otherwise hold.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_data_r.status;
  assign out_ch.image_width  = out_data_r.image_width;
  assign out_ch.image_height = out_data_r.image_height;

endmodule

FILE: sim/jpeg_header_dimension_scanner_test.sv
// ----------------------------------------------------------------------------
// jpeg_header_dimension_scanner_test: self-checking bench for the scanner
// Streams JPEG-like files through the input channel, tracks the expected
// parse in a scoreboard that mirrors the segment walk, and checks each
// result beat field by field under random idle and stall on both sides.
// ----------------------------------------------------------------------------
module jpeg_header_dimension_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jhds_pkg::*;

  localparam int         FRAME_BUFFER_BYTES = 512;
  localparam int         LIMIT_CYCLES       = 400000;
  localparam int         TARGET_BEATS       = 1000;
  localparam int         IDLE_PERCENT       = 28;
  // request code the block must ignore
  localparam logic [1:0] REQ_UNUSED         = 2'd3;
  // any non-frame marker used when a random pick lands on SOF0
  localparam logic [7:0] MARKER_DHT         = 8'hC4;

  typedef enum logic [2:0] {
    SCAN_SOI, SCAN_HEADER, SCAN_SKIP, SCAN_FRAME, SCAN_DONE
  } scan_phase_e;

  // Mirror of the segment walk; holds the results still owed by the block.
  class frame_size_tracker;
    scan_phase_e  phase;
    logic [15:0]  soi_window;
    logic [1:0]   hdr_pos;
    logic [15:0]  marker;
    logic [15:0]  remaining;
    logic [15:0]  content_pos;
    logic [15:0]  height;
    logic [15:0]  width;
    jhds_result_t results_due[$];
    int           errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase       = SCAN_SOI;
      soi_window  = '0;
      hdr_pos     = '0;
      marker      = '0;
      remaining   = '0;
      content_pos = '0;
      height      = '0;
      width       = '0;
    endfunction

    function void post(logic [1:0] st, logic [15:0] w, logic [15:0] h);
      jhds_result_t r;
      r.status       = st;
      r.image_width  = w;
      r.image_height = h;
      results_due.push_back(r);
      phase = SCAN_DONE;
    endfunction

    function void close_header();
      if (remaining <= 16'd2 || marker[15:8] != MARKER_PREFIX) begin
        post(ST_FMT, '0, '0);
        return;
      end
      remaining   = remaining - 16'd2;
      content_pos = '0;
      if (marker[7:0] == MARKER_SOF0) begin
        if (remaining > FRAME_BUFFER_BYTES) post(ST_MEM, '0, '0);
        else if (remaining < FRAME_MIN_BYTES) post(ST_FMT, '0, '0);
        else phase = SCAN_FRAME;
      end else begin
        phase = SCAN_SKIP;
      end
    endfunction

    function void note_beat(logic [1:0] req, logic [7:0] b);
      case (req)
        REQ_START: clear();
        REQ_EOS: begin
          case (phase)
            SCAN_SOI, SCAN_HEADER, SCAN_FRAME: post(ST_IO, '0, '0);
            SCAN_SKIP: post(ST_FMT, '0, '0);
            default: ;
          endcase
        end
        REQ_DATA: begin
          case (phase)
            SCAN_SOI: begin
              soi_window = {soi_window[7:0], b};
              if (soi_window == {MARKER_PREFIX, MARKER_SOI}) begin
                phase   = SCAN_HEADER;
                hdr_pos = '0;
              end
            end
            SCAN_HEADER: begin
              case (hdr_pos)
                2'd0: marker = {b, 8'h00};
                2'd1: marker[7:0] = b;
                2'd2: remaining = {b, 8'h00};
                default: remaining[7:0] = b;
              endcase
              if (hdr_pos == 2'd3) begin
                hdr_pos = '0;
                close_header();
              end else begin
                hdr_pos = hdr_pos + 2'd1;
              end
            end
            SCAN_SKIP: begin
              remaining = remaining - 16'd1;
              if (remaining == '0) begin
                phase   = SCAN_HEADER;
                hdr_pos = '0;
              end
            end
            SCAN_FRAME: begin
              // height sits in content bytes 1-2, width in 3-4, big-endian
              case (content_pos)
                16'd1: height = {b, 8'h00};
                16'd2: height[7:0] = b;
                16'd3: width = {b, 8'h00};
                16'd4: width[7:0] = b;
                default: ;
              endcase
              content_pos = content_pos + 16'd1;
              remaining   = remaining - 16'd1;
              if (remaining == '0) post(ST_OK, width, height);
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    endfunction

    function void check_result(jhds_result_t got);
      jhds_result_t want;
      if (results_due.size() == 0) begin
        $display("%0t: result beat with none due: status=%0d width=%0d height=%0d",
                 $time, got.status, got.image_width, got.image_height);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.image_width !== want.image_width) begin
        $display("%0t: image_width expected %0d actual %0d",
                 $time, want.image_width, got.image_width);
        errors++;
      end
      if (got.image_height !== want.image_height) begin
        $display("%0t: image_height expected %0d actual %0d",
                 $time, want.image_height, got.image_height);
        errors++;
      end
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic steady;        // high during the stretch with no idling on either side
  int   beats_sent;
  int   cycle_count;

  frame_size_tracker sb;
  logic [7:0]        file_bytes[$];

  jhds_in_if  in_ch ();
  jhds_out_if out_ch ();

  jpeg_header_dimension_scanner #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  // Drive one beat and hold it until the block takes it. Valid is only
  // dropped on an idle cycle, so back-to-back beats keep it high.
  task automatic send_beat(input logic [1:0] req, input logic [7:0] b);
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= req;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_beat(req, b);
    beats_sent++;
    steady <= (beats_sent >= 400 && beats_sent < 650);
  endtask

  // Hold the input off until every owed result has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Assemble one file: junk, SOI, a few skipped segments, then SOF0 and trailing junk.
  task automatic build_file();
    int       junk, segs, len, body, roll;
    logic [7:0] code;
    file_bytes = {};
    junk = $urandom_range(0, 3);
    repeat (junk) file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes.push_back(MARKER_PREFIX);
    file_bytes.push_back(MARKER_SOI);
    segs = $urandom_range(0, 3);
    repeat (segs) begin
      code = 8'($urandom_range(0, 255));
      if (code == MARKER_SOF0) code = MARKER_DHT;
      // corrupt the prefix now and then
      if ($urandom_range(0, 19) == 0) file_bytes.push_back(8'($urandom_range(0, 254)));
      else file_bytes.push_back(MARKER_PREFIX);
      file_bytes.push_back(code);
      // a length that cannot even cover itself, now and then
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      file_bytes.push_back(8'(len >> 8));
      file_bytes.push_back(8'(len));
      for (int j = 2; j < len; j++) file_bytes.push_back(8'($urandom_range(0, 255)));
    end
    roll = $urandom_range(0, 99);
    if (roll < 80) body = $urandom_range(5, 16);
    else if (roll < 92) body = $urandom_range(0, 4);
    else if (roll < 94) body = $urandom_range(FRAME_BUFFER_BYTES - 8, FRAME_BUFFER_BYTES);
    else body = $urandom_range(FRAME_BUFFER_BYTES + 1, 65533);
    len = body + 2;
    file_bytes.push_back(MARKER_PREFIX);
    file_bytes.push_back(MARKER_SOF0);
    file_bytes.push_back(8'(len >> 8));
    file_bytes.push_back(8'(len));
    // an oversized frame is rejected at its header, so skip its body
    if (body <= FRAME_BUFFER_BYTES)
      repeat (body) file_bytes.push_back(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 2)) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Send one random scan: a whole file, a file cut short, or pure noise.
  task automatic send_scan();
    int roll, cut;
    send_beat(REQ_START, 8'($urandom_range(0, 255)));
    roll = $urandom_range(0, 99);
    if (roll < 90) begin
      build_file();
      cut = (roll < 70) ? file_bytes.size() : $urandom_range(0, file_bytes.size() - 1);
      for (int i = 0; i < cut; i++) send_beat(REQ_DATA, file_bytes[i]);
      if (roll >= 70 || $urandom_range(0, 1) == 1)
        send_beat(REQ_EOS, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(4, 24))
        send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: check every accepted beat, stall at random.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.status, out_ch.image_width, out_ch.image_height});
      out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Watchdog: end the run if the stream hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int scans;
    sb              = new();
    steady          = 1'b0;
    beats_sent      = 0;
    scans           = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_DATA;
    in_ch.data_byte = 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: end of stream while hunting for SOI, then ignored once done.
    send_beat(REQ_EOS, 8'h00);
    send_beat(REQ_EOS, 8'hFF);
    send_beat(REQ_START, 8'h00);
    send_beat(REQ_UNUSED, 8'hA5);
    // Smallest legal frame with both dimensions at their maximum.
    send_beat(REQ_DATA, MARKER_PREFIX);
    send_beat(REQ_DATA, MARKER_SOI);
    send_beat(REQ_DATA, MARKER_PREFIX);
    send_beat(REQ_DATA, MARKER_SOF0);
    send_beat(REQ_DATA, 8'h00);
    send_beat(REQ_DATA, 8'h07);
    send_beat(REQ_DATA, 8'h00);
    repeat (4) send_beat(REQ_DATA, 8'hFF);
    // Bad marker prefix in the first header.
    send_beat(REQ_START, 8'hFF);
    send_beat(REQ_DATA, MARKER_PREFIX);
    send_beat(REQ_DATA, MARKER_SOI);
    send_beat(REQ_DATA, 8'h00);
    send_beat(REQ_DATA, MARKER_SOF0);
    send_beat(REQ_DATA, 8'h00);
    send_beat(REQ_DATA, 8'h05);

    // Random scans; drain the result side every so often.
    while (beats_sent < TARGET_BEATS) begin
      if (scans % 8 == 7) drain();
      send_scan();
      scans++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: jpeg_header_dimension_scanner.f
src/jhds_pkg.sv
src/jhds_in_if.sv
src/jhds_out_if.sv
src/jhds_core.sv
src/jpeg_header_dimension_scanner.sv
sim/jpeg_header_dimension_scanner_test.sv
